@@ rtl/q2e_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// q2e_pkg
// Shared constants and the arctangent table for the quaternion to Euler
// angle converter.
// ----------------------------------------------------------------------------
package q2e_pkg;

  // Width of the CORDIC angle accumulator (radians times 2^24).
  localparam int ZW = 28;

  localparam logic signed [ZW-1:0] HALF_PI_Z = 28'sd26353589;
  localparam int PI_OUT      = 25736;
  localparam int HALF_PI_OUT = 12868;
  localparam int TABLE_LEN   = 24;

  // Rounded atan(2^-i) in radians times 2^24.
  function automatic logic signed [ZW-1:0] atan_tab(input int i);
    logic signed [ZW-1:0] r;
    case (i)
      0:       r = 28'sd13176795;
      1:       r = 28'sd7778716;
      2:       r = 28'sd4110060;
      3:       r = 28'sd2086331;
      4:       r = 28'sd1047214;
      5:       r = 28'sd524117;
      6:       r = 28'sd262123;
      7:       r = 28'sd131069;
      8:       r = 28'sd65536;
      9:       r = 28'sd32768;
      10:      r = 28'sd16384;
      11:      r = 28'sd8192;
      12:      r = 28'sd4096;
      13:      r = 28'sd2048;
      14:      r = 28'sd1024;
      15:      r = 28'sd512;
      16:      r = 28'sd256;
      17:      r = 28'sd128;
      18:      r = 28'sd64;
      19:      r = 28'sd32;
      20:      r = 28'sd16;
      21:      r = 28'sd8;
      22:      r = 28'sd4;
      23:      r = 28'sd2;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/quaternion_to_euler_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_to_euler_top
// Converts a quaternion to ZYX Euler angles (roll, pitch, yaw).
// Pipelined: the square root resolves one result bit per stage and the CORDIC
// runs one iteration per stage.
// Throughput: one word per cycle; busy stays low and the receiver cannot stall.
// Reset clears all valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
module quaternion_to_euler_top #(
  parameter int CORDIC_STEPS = 16,
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic signed [SAMPLE_WIDTH-1:0] quat_x_i,
  input  logic signed [SAMPLE_WIDTH-1:0] quat_y_i,
  input  logic signed [SAMPLE_WIDTH-1:0] quat_z_i,
  input  logic signed [SAMPLE_WIDTH-1:0] quat_w_i,
  output logic                        valid_o,
  output logic signed [15:0]          roll_angle_o,
  output logic signed [14:0]          pitch_angle_o,
  output logic signed [15:0]          yaw_angle_o,
  output logic                        pitch_clamped_o
);

  localparam int W   = SAMPLE_WIDTH;
  localparam int N   = CORDIC_STEPS;
  localparam int F   = W - 1;
  localparam int PW  = W + 2;
  localparam int SW  = W + 4;
  localparam int RW  = 2 * F + 2;
  localparam int LAT = W + N + 6;
  localparam logic signed [SW-1:0] ONE_S = {{(SW-W){1'b0}}, 1'b1, {F{1'b0}}};

  logic accept;
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Stage 1: doubled products.
  logic signed [2*W-1:0] p_wx, p_yz, p_xx, p_yy, p_zz, p_wz, p_xy, p_wy, p_zx;
  logic signed [PW-1:0]  t_wx_q, t_yz_q, t_xx_q, t_yy_q, t_zz_q;
  logic signed [PW-1:0]  t_wz_q, t_xy_q, t_wy_q, t_zx_q;
  logic                  v1_q;

  assign p_wx = quat_w_i * quat_x_i;
  assign p_yz = quat_y_i * quat_z_i;
  assign p_xx = quat_x_i * quat_x_i;
  assign p_yy = quat_y_i * quat_y_i;
  assign p_zz = quat_z_i * quat_z_i;
  assign p_wz = quat_w_i * quat_z_i;
  assign p_xy = quat_x_i * quat_y_i;
  assign p_wy = quat_w_i * quat_y_i;
  assign p_zx = quat_z_i * quat_x_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    t_wx_q <= PW'(p_wx >>> (W - 2));
    t_yz_q <= PW'(p_yz >>> (W - 2));
    t_xx_q <= PW'(p_xx >>> (W - 2));
    t_yy_q <= PW'(p_yy >>> (W - 2));
    t_zz_q <= PW'(p_zz >>> (W - 2));
    t_wz_q <= PW'(p_wz >>> (W - 2));
    t_xy_q <= PW'(p_xy >>> (W - 2));
    t_wy_q <= PW'(p_wy >>> (W - 2));
    t_zx_q <= PW'(p_zx >>> (W - 2));
  end

  // Stage 2: product sums, sine term and its clamp test.
  logic signed [SW-1:0] s_d, mag_d;
  logic signed [SW-1:0] rx_q2, ry_q2, yx_q2, yy_q2, s_q2;
  logic                 cl_q2, v2_q;
  logic [F-1:0]         magl_q;

  assign s_d   = SW'(t_wy_q) - SW'(t_zx_q);
  assign mag_d = (s_d < 0) ? -s_d : s_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ry_q2  <= SW'(t_wx_q) + SW'(t_yz_q);
    rx_q2  <= ONE_S - (SW'(t_xx_q) + SW'(t_yy_q));
    yy_q2  <= SW'(t_wz_q) + SW'(t_xy_q);
    yx_q2  <= ONE_S - (SW'(t_yy_q) + SW'(t_zz_q));
    s_q2   <= s_d;
    cl_q2  <= mag_d >= ONE_S;
    magl_q <= mag_d[F-1:0];
  end

  // Stage 3 and square root stages: one result bit per stage.
  logic [2*F-1:0]       sq;
  logic [RW-1:0]        rem_q [0:F+1];
  logic [RW-1:0]        res_q [0:F+1];
  logic signed [SW-1:0] rx_q [0:F+1];
  logic signed [SW-1:0] ry_q [0:F+1];
  logic signed [SW-1:0] yx_q [0:F+1];
  logic signed [SW-1:0] yy_q [0:F+1];
  logic signed [SW-1:0] s_q  [0:F+1];
  logic                 cl_q [0:F+1];
  logic                 vs_q [0:F+1];

  assign sq = magl_q * magl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vs_q[0] <= 1'b0;
    end else begin
      vs_q[0] <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q[0] <= (RW'(1) << (2 * F)) - RW'(sq);
    res_q[0] <= '0;
    rx_q[0]  <= rx_q2;
    ry_q[0]  <= ry_q2;
    yx_q[0]  <= yx_q2;
    yy_q[0]  <= yy_q2;
    s_q[0]   <= s_q2;
    cl_q[0]  <= cl_q2;
  end

  for (genvar j = 0; j <= F; j++) begin : g_sqrt
    localparam int K = F - j;
    logic [RW-1:0] trial;
    assign trial = (res_q[j] << (K + 1)) + (RW'(1) << (2 * K));

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vs_q[j+1] <= 1'b0;
      end else begin
        vs_q[j+1] <= vs_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (rem_q[j] >= trial) begin
        rem_q[j+1] <= rem_q[j] - trial;
        res_q[j+1] <= res_q[j] | (RW'(1) << K);
      end else begin
        rem_q[j+1] <= rem_q[j];
        res_q[j+1] <= res_q[j];
      end
      rx_q[j+1] <= rx_q[j];
      ry_q[j+1] <= ry_q[j];
      yx_q[j+1] <= yx_q[j];
      yy_q[j+1] <= yy_q[j];
      s_q[j+1]  <= s_q[j];
      cl_q[j+1] <= cl_q[j];
    end
  end

  // CORDIC units for the three angles.
  logic signed [SW-1:0] cos_p;
  logic signed [15:0]   roll_c, yaw_c;
  logic signed [14:0]   pitch_c;
  logic                 pv_c;

  assign cos_p = SW'(res_q[F+1][F:0]);

  q2e_cordic #(.IW(SW), .STEPS(N), .OW(16), .LIM(q2e_pkg::PI_OUT)) u_roll (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vs_q[F+1]),
    .x_i     (rx_q[F+1]),
    .y_i     (ry_q[F+1]),
    .valid_o (),
    .angle_o (roll_c)
  );

  q2e_cordic #(.IW(SW), .STEPS(N), .OW(16), .LIM(q2e_pkg::PI_OUT)) u_yaw (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vs_q[F+1]),
    .x_i     (yx_q[F+1]),
    .y_i     (yy_q[F+1]),
    .valid_o (),
    .angle_o (yaw_c)
  );

  q2e_cordic #(.IW(SW), .STEPS(N), .OW(15), .LIM(q2e_pkg::HALF_PI_OUT)) u_pitch (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vs_q[F+1]),
    .x_i     (cos_p),
    .y_i     (s_q[F+1]),
    .valid_o (pv_c),
    .angle_o (pitch_c)
  );

  // Clamp flag and sine sign follow the CORDIC latency.
  logic clc_q [0:N+1];
  logic pos_q [0:N+1];

  always_ff @(posedge clk_i) begin
    clc_q[0] <= cl_q[F+1];
    pos_q[0] <= s_q[F+1] > 0;
  end

  for (genvar d = 0; d < N + 1; d++) begin : g_side
    always_ff @(posedge clk_i) begin
      clc_q[d+1] <= clc_q[d];
      pos_q[d+1] <= pos_q[d];
    end
  end

  // Output registers.
  localparam logic signed [14:0] HP_O = 15'(q2e_pkg::HALF_PI_OUT);

  logic valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= pv_c;
    end
  end

  always_ff @(posedge clk_i) begin
    roll_angle_o    <= roll_c;
    yaw_angle_o     <= yaw_c;
    pitch_clamped_o <= clc_q[N+1];
    if (clc_q[N+1]) begin
      pitch_angle_o <= pos_q[N+1] ? HP_O : -HP_O;
    end else begin
      pitch_angle_o <= pitch_c;
    end
  end

  assign valid_o = valid_q;

  // Checks.
  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##LAT valid_o)
    else $error("result word missing after fixed latency");

  a_clamp : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && pitch_clamped_o) |-> (pitch_angle_o == HP_O || pitch_angle_o == -HP_O))
    else $error("clamped pitch is not a quarter turn");

  a_pitch_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (pitch_angle_o <= HP_O && pitch_angle_o >= -HP_O))
    else $error("pitch out of range");

endmodule

@@ rtl/q2e_cordic.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// q2e_cordic
// Pipelined vectoring CORDIC: atan2(y, x) with quadrant pre-rotation,
// one iteration per stage, rounding and saturation to +-LIM.
// ----------------------------------------------------------------------------
module q2e_cordic #(
  parameter int IW    = 20,
  parameter int STEPS = 16,
  parameter int OW    = 16,
  parameter int LIM   = 25736
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  logic signed [IW-1:0] x_i,
  input  logic signed [IW-1:0] y_i,
  output logic                 valid_o,
  output logic signed [OW-1:0] angle_o
);

  localparam int CW = IW + 3;
  localparam int ZW = q2e_pkg::ZW;
  localparam logic signed [ZW-1:0] LIM_Z = ZW'(LIM);
  localparam logic signed [ZW-1:0] RND_Z = ZW'(1024);

  logic signed [CW-1:0] x_q [0:STEPS];
  logic signed [CW-1:0] y_q [0:STEPS];
  logic signed [ZW-1:0] z_q [0:STEPS];
  logic                 zero_q [0:STEPS];
  logic                 vld_q [0:STEPS];

  logic signed [CW-1:0] xe, ye;
  logic signed [CW-1:0] x0_d, y0_d;
  logic signed [ZW-1:0] z0_d;

  assign xe = CW'(x_i);
  assign ye = CW'(y_i);

  // Rotate vectors in the left half plane by a quarter turn.
  always_comb begin
    x0_d = xe;
    y0_d = ye;
    z0_d = '0;
    if (xe < 0) begin
      if (ye >= 0) begin
        x0_d = ye;
        y0_d = -xe;
        z0_d = q2e_pkg::HALF_PI_Z;
      end else begin
        x0_d = -ye;
        y0_d = xe;
        z0_d = -q2e_pkg::HALF_PI_Z;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q[0]    <= x0_d;
    y_q[0]    <= y0_d;
    z_q[0]    <= z0_d;
    zero_q[0] <= (x_i == '0) && (y_i == '0);
  end

  // One micro-rotation per stage.
  for (genvar i = 0; i < STEPS; i++) begin : g_iter
    logic signed [CW-1:0] xs, ys;
    assign xs = x_q[i] >>> i;
    assign ys = y_q[i] >>> i;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i+1] <= 1'b0;
      end else begin
        vld_q[i+1] <= vld_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      zero_q[i+1] <= zero_q[i];
      if (y_q[i] >= 0) begin
        x_q[i+1] <= x_q[i] + ys;
        y_q[i+1] <= y_q[i] - xs;
        z_q[i+1] <= z_q[i] + q2e_pkg::atan_tab(i);
      end else begin
        x_q[i+1] <= x_q[i] - ys;
        y_q[i+1] <= y_q[i] + xs;
        z_q[i+1] <= z_q[i] - q2e_pkg::atan_tab(i);
      end
    end
  end

  // Round to radians times 2^13 and saturate.
  logic signed [ZW-1:0] rnd, sat;
  logic signed [OW-1:0] angle_q;
  logic                 valid_q;

  assign rnd = (z_q[STEPS] + RND_Z) >>> 11;

  always_comb begin
    sat = rnd;
    if (rnd > LIM_Z) begin
      sat = LIM_Z;
    end else if (rnd < -LIM_Z) begin
      sat = -LIM_Z;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= vld_q[STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    angle_q <= zero_q[STEPS] ? '0 : OW'(sat);
  end

  assign valid_o = valid_q;
  assign angle_o = angle_q;

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for quaternion_to_euler_top. A short table of directed
// quaternions runs first, then about a thousand random words. Every word that
// is accepted goes through a bit-exact model of the CORDIC datapath. Each
// strobed result is compared with the oldest angle set that is still waiting.
// ----------------------------------------------------------------------------
module tb;

  localparam int SW       = 16;
  localparam int STEPS    = 16;
  localparam int LATENCY  = SW + STEPS + 6;
  localparam int N_RANDOM = 1000;
  localparam longint ONE_Q  = 64'sd1 <<< (SW - 1);
  localparam longint HPI_Z  = 64'sd26353589;
  localparam longint PI_A   = 64'sd25736;
  localparam longint HPI_A  = 64'sd12868;

  typedef struct packed {
    logic signed [15:0] roll;
    logic signed [14:0] pitch;
    logic signed [15:0] yaw;
    logic               clamped;
  } angles_t;

  // One directed row. Pitch and the clamp flag are typed in only where they
  // are obvious; all other fields come from the model below.
  typedef struct {
    logic signed [SW-1:0] x, y, z, w;
    bit                   pitch_typed;
    logic signed [14:0]   pitch;
    logic                 clamped;
  } quat_row_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic signed [SW-1:0] quat_x_i = '0, quat_y_i = '0, quat_z_i = '0, quat_w_i = '0;
  logic                 valid_o;
  logic signed [15:0]   roll_angle_o;
  logic signed [14:0]   pitch_angle_o;
  logic signed [15:0]   yaw_angle_o;
  logic                 pitch_clamped_o;

  angles_t pending_angles[$];
  int      mismatch_count = 0;
  int      unexpected_count = 0;
  int      words_sent = 0;
  int      results_seen = 0;
  int      clamped_seen = 0;
  int      idle_pct = 0;

  longint atan_rad24[STEPS] = '{13176795, 7778716, 4110060, 2086331, 1047214, 524117,
                                262123, 131069, 65536, 32768, 16384, 8192, 4096,
                                2048, 1024, 512};

  quaternion_to_euler_top #(.CORDIC_STEPS(STEPS), .SAMPLE_WIDTH(SW)) dut (
    .clk_i, .rst_ni, .start, .busy,
    .quat_x_i, .quat_y_i, .quat_z_i, .quat_w_i,
    .valid_o, .roll_angle_o, .pitch_angle_o, .yaw_angle_o, .pitch_clamped_o
  );

  // Clock, 10 ns period.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Run limit.
  initial begin
    #5ms;
    $display("Timeout with %0d results outstanding", pending_angles.size());
    $display("CHECK FAILED");
    $finish;
  end

  // 2ab with the fraction kept at SW-1 bits, floor shift.
  function automatic longint twice_prod(longint a, longint b);
    return (a * b) >>> (SW - 2);
  endfunction

  function automatic longint floor_sqrt(longint unsigned r);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > r) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (r >= res + bitv) begin
        r = r - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return longint'(res);
  endfunction

  // Vectoring CORDIC arctangent, radians times 2^13, saturated to +-lim.
  function automatic longint cordic_angle(longint y, longint x, longint lim);
    longint acc, t, xs, ys, o;
    acc = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; acc = HPI_Z;
      end else begin
        t = x; x = -y; y = t; acc = -HPI_Z;
      end
    end
    for (int i = 0; i < STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys; y = y - xs; acc = acc + atan_rad24[i];
      end else begin
        x = x - ys; y = y + xs; acc = acc - atan_rad24[i];
      end
    end
    o = (acc + 1024) >>> 11;
    if (o > lim) o = lim;
    if (o < -lim) o = -lim;
    return o;
  endfunction

  function automatic angles_t euler_of(longint qx, longint qy, longint qz, longint qw);
    angles_t a;
    longint xx, yy, zz, s, mag, c;
    xx = twice_prod(qx, qx);
    yy = twice_prod(qy, qy);
    zz = twice_prod(qz, qz);
    a.roll = 16'(cordic_angle(twice_prod(qw, qx) + twice_prod(qy, qz), ONE_Q - (xx + yy), PI_A));
    a.yaw  = 16'(cordic_angle(twice_prod(qw, qz) + twice_prod(qx, qy), ONE_Q - (yy + zz), PI_A));
    s = twice_prod(qw, qy) - twice_prod(qz, qx);
    mag = (s < 0) ? -s : s;
    if (mag >= ONE_Q) begin
      a.clamped = 1'b1;
      a.pitch = 15'((s > 0) ? HPI_A : -HPI_A);
    end else begin
      c = floor_sqrt(longint'(64'd1 << (2 * (SW - 1))) - mag * mag);
      a.clamped = 1'b0;
      a.pitch = 15'(cordic_angle(s, c, HPI_A));
    end
    return a;
  endfunction

  // Drive one word from the falling edge and hold it until it is taken.
  task automatic send_word(logic signed [SW-1:0] x, y, z, w,
                           bit typed, logic signed [14:0] tp, logic tc);
    angles_t a;
    while ($urandom_range(0, 99) < idle_pct) begin
      start = 1'b0;
      @(negedge clk_i);
    end
    start = 1'b1;
    quat_x_i = x; quat_y_i = y; quat_z_i = z; quat_w_i = w;
    forever begin
      @(posedge clk_i);
      if (!busy) break;
    end
    a = euler_of(x, y, z, w);
    if (typed) begin
      a.pitch = tp;
      a.clamped = tc;
    end
    pending_angles.insert(pending_angles.size(), a);
    words_sent++;
    @(negedge clk_i);
  endtask

  // Result checker.
  always @(posedge clk_i) begin
    angles_t e;
    if (rst_ni && valid_o) begin
      results_seen++;
      if (pitch_clamped_o) clamped_seen++;
      if (pending_angles.size() == 0) begin
        unexpected_count++;
        if (unexpected_count <= 10) $display("Result word with nothing pending");
      end else begin
        e = pending_angles.pop_front();
        if (roll_angle_o !== e.roll || pitch_angle_o !== e.pitch ||
            yaw_angle_o !== e.yaw || pitch_clamped_o !== e.clamped) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("Mismatch: roll %0d/%0d pitch %0d/%0d yaw %0d/%0d clamp %0b/%0b (exp/got)",
                     e.roll, roll_angle_o, e.pitch, pitch_angle_o, e.yaw, yaw_angle_o,
                     e.clamped, pitch_clamped_o);
        end
      end
    end
  end

  quat_row_t directed_rows[] = '{
    '{16'sd0, 16'sd0, 16'sd0, 16'sd32767, 1'b0, 15'sd0, 1'b0},       // identity
    '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, 15'sd0, 1'b0},           // zero vector
    '{16'sd0, -16'sd32768, 16'sd0, -16'sd32768, 1'b1, 15'sd12868, 1'b1},
    '{16'sd0, 16'sd32767, 16'sd0, -16'sd32768, 1'b1, -15'sd12868, 1'b1},
    '{16'sd23170, 16'sd0, 16'sd0, 16'sd23170, 1'b0, 15'sd0, 1'b0},    // roll +pi/2
    '{16'sd32767, 16'sd0, 16'sd0, 16'sd0, 1'b0, 15'sd0, 1'b0},        // roll pi
    '{16'sd0, 16'sd0, 16'sd32767, 16'sd0, 1'b0, 15'sd0, 1'b0},        // yaw pi
    '{16'sd0, 16'sd0, -16'sd32768, 16'sd0, 1'b0, 15'sd0, 1'b0},
    '{16'sd0, 16'sd23170, 16'sd0, 16'sd23170, 1'b0, 15'sd0, 1'b0},    // just below lock
    '{16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384, 1'b0, 15'sd0, 1'b0},
    '{-16'sd16384, 16'sd16384, 16'sd16384, -16'sd16384, 1'b0, 15'sd0, 1'b0},
    '{16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 1'b0, 15'sd0, 1'b0},
    '{-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, 1'b0, 15'sd0, 1'b0},
    '{-16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767, 1'b0, 15'sd0, 1'b0},
    '{16'sd1, -16'sd1, 16'sd1, -16'sd1, 1'b0, 15'sd0, 1'b0},
    '{16'sd0, 16'sd0, 16'sd1, 16'sd0, 1'b0, 15'sd0, 1'b0}
  };

  // Stimulus.
  initial begin
    logic signed [SW-1:0] qx, qy, qz, qw;
    longint rest;
    int phase_len, guard;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[i])
      send_word(directed_rows[i].x, directed_rows[i].y, directed_rows[i].z,
                directed_rows[i].w, directed_rows[i].pitch_typed,
                directed_rows[i].pitch, directed_rows[i].clamped);

    // Let the pipe drain completely once before the random part.
    start = 1'b0;
    while (pending_angles.size() != 0) @(negedge clk_i);

    phase_len = N_RANDOM / 3;
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n < phase_len) idle_pct = 32;
      else if (n < 2 * phase_len) idle_pct = 86;
      else idle_pct = 0;
      case ($urandom_range(0, 19))
        // Near-unit quaternion with w closing the norm.
        0, 1, 2, 3, 4, 5, 6, 7, 8, 9: begin
          qx = SW'($signed($urandom_range(0, 36000)) - 18000);
          qy = SW'($signed($urandom_range(0, 36000)) - 18000);
          qz = SW'($signed($urandom_range(0, 36000)) - 18000);
          rest = 64'sd1073676289 - longint'(qx) * qx - longint'(qy) * qy - longint'(qz) * qz;
          qw = (rest > 0) ? SW'(floor_sqrt(rest)) : '0;
          if ($urandom_range(0, 1)) qw = -qw;
        end
        // Around gimbal lock: w = +-y and z = +-x.
        10, 11, 12: begin
          qx = SW'($urandom_range(0, 8000));
          qy = SW'($urandom_range(21000, 23200));
          qz = $urandom_range(0, 1) ? qx : -qx;
          qw = $urandom_range(0, 1) ? qy : -qy;
          if ($urandom_range(0, 1)) qy = -qy;
        end
        default: begin
          qx = SW'($urandom);
          qy = SW'($urandom);
          qz = SW'($urandom);
          qw = SW'($urandom);
        end
      endcase
      send_word(qx, qy, qz, qw, 1'b0, 15'sd0, 1'b0);
    end
    start = 1'b0;

    guard = 0;
    while (pending_angles.size() != 0 && guard < 100 * LATENCY) begin
      @(negedge clk_i);
      guard++;
    end
    repeat (2 * LATENCY) @(negedge clk_i);

    $display("Sent %0d quaternions, checked %0d angle sets, %0d with pitch clamped.",
             words_sent, results_seen, clamped_seen);
    $display("Mismatches %0d, stray results %0d, still pending %0d.",
             mismatch_count, unexpected_count, pending_angles.size());
    if (mismatch_count == 0 && unexpected_count == 0 && pending_angles.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/q2e_pkg.sv
rtl/q2e_cordic.sv
rtl/quaternion_to_euler_top.sv
test/tb.sv
